>>> rtl/bcmq_pkg.sv
// Shared types and constants for the baseline-calibrated motion quantiser.
// No dependencies; every other file of the block imports this package.
package bcmq_pkg;

  localparam int unsigned CalSamples = 100;
  localparam int unsigned CntW       = 7;
  localparam int unsigned AccW       = 15;

  // floor(x / CalSamples) == (x * DivMul) >> DivShift for every x below 2**AccW
  localparam int unsigned DivMul   = 5243;
  localparam int unsigned DivMulW  = 13;
  localparam int unsigned DivShift = 19;
  localparam int unsigned ProdW    = AccW + DivMulW;

  localparam logic [7:0] CodeNegLarge  = 8'd0;
  localparam logic [7:0] CodeNegMedium = 8'd42;
  localparam logic [7:0] CodeNegSmall  = 8'd84;
  localparam logic [7:0] CodeStill     = 8'd126;
  localparam logic [7:0] CodePosSmall  = 8'd168;
  localparam logic [7:0] CodePosMedium = 8'd210;
  localparam logic [7:0] CodePosLarge  = 8'd255;
  localparam logic [7:0] CodeBlink     = 8'd255;

  typedef enum logic [1:0] {
    CFG_MOVE_SMALL  = 2'd0,
    CFG_MOVE_MEDIUM = 2'd1,
    CFG_MOVE_LARGE  = 2'd2,
    CFG_BLINK_THR   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] x_sample;
    logic [7:0] y_sample;
    logic [7:0] light_sample;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] x_code;
    logic [7:0] y_code;
    logic [7:0] blink_code;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] move_small;
    logic [7:0] move_medium;
    logic [7:0] move_large;
    logic [7:0] blink_threshold;
  } thr_t;

  typedef struct packed {
    logic [7:0] code;
    logic       over_blink;
  } lane_res_t;

endpackage

>>> rtl/bcmq_div100.sv
// Divides a calibration sum by the sample count through a reciprocal multiply.
// Depends on bcmq_pkg.
module bcmq_div100 import bcmq_pkg::*; (
  input  logic [AccW-1:0] sum_i,
  output logic [7:0]      quot_o
);

  logic [ProdW-1:0] prod;

  assign prod   = ProdW'(sum_i) * ProdW'(DivMul);
  // quotient never exceeds 255, so eight bits hold it
  assign quot_o = prod[DivShift+7:DivShift];

endmodule

>>> rtl/bcmq_lane.sv
// One grading lane: offset of a sample from its baseline, graded to seven levels.
// Depends on bcmq_pkg.
module bcmq_lane import bcmq_pkg::*; (
  input  logic [7:0] sample_i,
  input  logic [7:0] base_i,
  input  thr_t       thr_i,
  output lane_res_t  res_o
);

  logic signed [8:0] d;
  logic signed [8:0] lg_p, lg_n, md_p, md_n, sm_p, sm_n, bl_p;

  always_comb begin
    d    = $signed({1'b0, sample_i}) - $signed({1'b0, base_i});
    lg_p = $signed({1'b0, thr_i.move_large});
    md_p = $signed({1'b0, thr_i.move_medium});
    sm_p = $signed({1'b0, thr_i.move_small});
    bl_p = $signed({1'b0, thr_i.blink_threshold});
    lg_n = 9'sd0 - lg_p;
    md_n = 9'sd0 - md_p;
    sm_n = 9'sd0 - sm_p;

    // first matching test wins, even with thresholds out of order
    if (d > lg_p)      res_o.code = CodePosLarge;
    else if (d < lg_n) res_o.code = CodeNegLarge;
    else if (d > md_p) res_o.code = CodePosMedium;
    else if (d < md_n) res_o.code = CodeNegMedium;
    else if (d > sm_p) res_o.code = CodePosSmall;
    else if (d < sm_n) res_o.code = CodeNegSmall;
    else               res_o.code = CodeStill;

    res_o.over_blink = (d > bl_p);
  end

endmodule

>>> rtl/baseline_calibrated_motion_quantizer_core.sv
// Baseline-calibrated motion quantiser, top level.
// Depends on bcmq_pkg, bcmq_div100 and bcmq_lane.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one beat of X, Y and
// light samples. The first 100 beats after reset are summed; they give no
// result except the 100th. On the 100th beat the sums are divided by 100 and
// kept as baselines, and that beat and every later one yield one output beat
// (out_valid_o/out_ready_i/out_data_o) holding the X and Y levels and the
// blink code.
// The path has three register stages: the input register, loaded at the
// accepting edge of the input beat, a baseline stage where the reciprocal
// multiply forms the baselines, and the output register fed by three grading
// lanes working in parallel. Throughput: one beat per cycle while out_ready_i
// does not stall the output.
// A stall on out_ready_i holds the output register and backs up the stages
// one by one; in_ready_o falls only when all three are full.
// Reset clears the sample count, sums, pipeline valids and restores the
// threshold registers (5, 10, 15, 50). Thresholds are written through
// cfg_we_i/cfg_idx_i/cfg_data_i with no wait and take effect at once.
module baseline_calibrated_motion_quantizer_core import bcmq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  cfg_idx_e  cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  thr_t thr_q;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AccW-1:0] x_acc_q, y_acc_q, l_acc_q;
  logic [7:0]      x_base_q, y_base_q, l_base_q;
  logic [7:0]      x_quot, y_quot, l_quot;

  logic      s1_valid_q, s1_last_q, s2_valid_q;
  in_beat_t  s1_data_q, s2_data_q;
  out_beat_t out_q;
  logic      out_valid_q;

  logic in_acc, cal_busy, emit;
  logic s1_adv, s2_adv, out_adv;
  lane_res_t x_res, y_res, l_res;

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.move_small      <= 8'd5;
      thr_q.move_medium     <= 8'd10;
      thr_q.move_large      <= 8'd15;
      thr_q.blink_threshold <= 8'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MOVE_SMALL:  thr_q.move_small      <= cfg_data_i;
        CFG_MOVE_MEDIUM: thr_q.move_medium     <= cfg_data_i;
        CFG_MOVE_LARGE:  thr_q.move_large      <= cfg_data_i;
        CFG_BLINK_THR:   thr_q.blink_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign out_adv    = !out_valid_q || out_ready_i;
  assign s2_adv     = s2_valid_q && out_adv;
  assign s1_adv     = s1_valid_q && (!s2_valid_q || s2_adv);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  assign cal_busy = (cnt_q != CntW'(CalSamples));
  assign cnt_d    = cnt_q + CntW'(1);
  // emit from the last calibration beat on
  assign emit     = !cal_busy || (cnt_d == CntW'(CalSamples));

  // calibration count and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      x_acc_q <= '0;
      y_acc_q <= '0;
      l_acc_q <= '0;
    end else if (in_acc && cal_busy) begin
      cnt_q   <= cnt_d;
      x_acc_q <= x_acc_q + AccW'(in_data_i.x_sample);
      y_acc_q <= y_acc_q + AccW'(in_data_i.y_sample);
      l_acc_q <= l_acc_q + AccW'(in_data_i.light_sample);
    end
  end

  // stage 1: input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_acc && emit;
      s1_last_q  <= cal_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_data_q <= in_data_i;
  end

  bcmq_div100 u_div_x (.sum_i(x_acc_q), .quot_o(x_quot));
  bcmq_div100 u_div_y (.sum_i(y_acc_q), .quot_o(y_quot));
  bcmq_div100 u_div_l (.sum_i(l_acc_q), .quot_o(l_quot));

  // latch baselines as the last calibration beat moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_base_q <= '0;
      y_base_q <= '0;
      l_base_q <= '0;
    end else if (s1_adv && s1_last_q) begin
      x_base_q <= x_quot;
      y_base_q <= y_quot;
      l_base_q <= l_quot;
    end
  end

  // stage 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s2_valid_q || s2_adv) begin
      s2_valid_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) s2_data_q <= s1_data_q;
  end

  bcmq_lane u_lane_x (
    .sample_i(s2_data_q.x_sample), .base_i(x_base_q), .thr_i(thr_q), .res_o(x_res));
  bcmq_lane u_lane_y (
    .sample_i(s2_data_q.y_sample), .base_i(y_base_q), .thr_i(thr_q), .res_o(y_res));
  bcmq_lane u_lane_l (
    .sample_i(s2_data_q.light_sample), .base_i(l_base_q), .thr_i(thr_q), .res_o(l_res));

  // merge lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_q.x_code     <= x_res.code;
      out_q.y_code     <= y_res.code;
      out_q.blink_code <= l_res.over_blink ? CodeBlink : CodeStill;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> verif/baseline_calibrated_motion_quantizer_core_test.sv
// Self-checking testbench for baseline_calibrated_motion_quantizer_core.
// Needs bcmq_pkg and the core RTL; predicts baselines and levels per sample beat.

module baseline_calibrated_motion_quantizer_core_test;
  import bcmq_pkg::*;

  logic      clk_i      = 1'b0;
  logic      rst_ni     = 1'b0;
  logic      cfg_we_i   = 1'b0;
  cfg_idx_e  cfg_idx_i  = CFG_MOVE_SMALL;
  logic [7:0] cfg_data_i = 8'd0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_data_i  = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_data_o;

  baseline_calibrated_motion_quantizer_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Threshold copy and calibration state of the predictor
  logic [7:0]  lim_small  = 8'd5;
  logic [7:0]  lim_medium = 8'd10;
  logic [7:0]  lim_large  = 8'd15;
  logic [7:0]  lim_blink  = 8'd50;
  int          cal_count  = 0;
  logic [14:0] x_sum = '0, y_sum = '0, light_sum = '0;
  int          x_base = 0, y_base = 0, light_base = 0;

  in_beat_t  pending_samples [$];
  out_beat_t expected_levels [$];
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  bit        in_taken       = 1'b0;

  task automatic report_mismatch(string what);
    $display("ERROR @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic logic [7:0] grade_offset(int d);
    if (d > int'(lim_large))  return CodePosLarge;
    if (d < -int'(lim_large)) return CodeNegLarge;
    if (d > int'(lim_medium)) return CodePosMedium;
    if (d < -int'(lim_medium)) return CodeNegMedium;
    if (d > int'(lim_small))  return CodePosSmall;
    if (d < -int'(lim_small)) return CodeNegSmall;
    return CodeStill;
  endfunction

  function automatic logic [7:0] clamp_sample(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Offset close to one of the movement thresholds or to zero, either sign
  function automatic int near_offset();
    int mag;
    case ($urandom_range(3))
      0: mag = int'(lim_small);
      1: mag = int'(lim_medium);
      2: mag = int'(lim_large);
      default: mag = 0;
    endcase
    mag = mag + int'($urandom_range(2)) - 1;
    return ($urandom_range(1) != 0) ? mag : -mag;
  endfunction

  // Sample driver; also sets out_ready_i
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_samples.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
          in_data_i  <= pending_samples.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  // Predict on each accepted sample beat, check each accepted level beat
  always @(posedge clk_i) begin
    out_beat_t got, want;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) begin
      if (cal_count < int'(CalSamples)) begin
        x_sum     = x_sum + in_data_i.x_sample;
        y_sum     = y_sum + in_data_i.y_sample;
        light_sum = light_sum + in_data_i.light_sample;
        cal_count++;
        // the last calibration beat fixes the baselines and is graded too
        if (cal_count == int'(CalSamples)) begin
          x_base     = int'(x_sum) / int'(CalSamples);
          y_base     = int'(y_sum) / int'(CalSamples);
          light_base = int'(light_sum) / int'(CalSamples);
        end
      end
      if (cal_count == int'(CalSamples)) begin
        want.x_code     = grade_offset(int'(in_data_i.x_sample) - x_base);
        want.y_code     = grade_offset(int'(in_data_i.y_sample) - y_base);
        want.blink_code = (int'(in_data_i.light_sample) - light_base > int'(lim_blink)) ?
                          CodeBlink : CodeStill;
        expected_levels.push_back(want);
      end
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("level beat %h with nothing expected", got));
      end else begin
        want = expected_levels.pop_front();
        if (got.x_code != want.x_code)
          report_mismatch($sformatf("x_code got %0d want %0d", got.x_code, want.x_code));
        if (got.y_code != want.y_code)
          report_mismatch($sformatf("y_code got %0d want %0d", got.y_code, want.y_code));
        if (got.blink_code != want.blink_code)
          report_mismatch($sformatf("blink_code got %0d want %0d",
                                    got.blink_code, want.blink_code));
      end
    end
  end

  task automatic write_threshold(cfg_idx_e idx, logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    case (idx)
      CFG_MOVE_SMALL:  lim_small  = value;
      CFG_MOVE_MEDIUM: lim_medium = value;
      CFG_MOVE_LARGE:  lim_large  = value;
      default:         lim_blink  = value;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic apply_thresholds(logic [7:0] sm, logic [7:0] md, logic [7:0] lg,
                                  logic [7:0] bl);
    write_threshold(CFG_MOVE_SMALL, sm);
    write_threshold(CFG_MOVE_MEDIUM, md);
    write_threshold(CFG_MOVE_LARGE, lg);
    write_threshold(CFG_BLINK_THR, bl);
  endtask

  // Wait until every sample is taken and every level beat is back,
  // then let any beats still inside the pipeline run out
  task automatic drain_levels();
    int guard;
    guard = 0;
    do @(posedge clk_i); while (pending_samples.size() != 0 || in_valid_i);
    while (expected_levels.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    in_beat_t s;
    int offs [$];
    int sm, md, lg;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Calibration with both extremes present, thresholds changed half way
    pending_samples.push_back('{8'h00, 8'hFF, 8'h00});
    pending_samples.push_back('{8'hFF, 8'h00, 8'hFF});
    for (int i = 0; i < 48; i++)
      pending_samples.push_back(in_beat_t'(24'($urandom)));
    drain_levels();
    write_threshold(CFG_BLINK_THR, 8'd30);
    for (int i = 0; i < 50; i++)
      pending_samples.push_back(in_beat_t'(24'($urandom)));
    drain_levels();

    // Directed: each threshold boundary on both sides, and full-scale samples
    sm = int'(lim_small);
    md = int'(lim_medium);
    lg = int'(lim_large);
    offs = '{0, sm, -sm, sm + 1, -sm - 1, md, -md, md + 1, -md - 1,
             lg, -lg, lg + 1, -lg - 1};
    foreach (offs[k]) begin
      s.x_sample     = clamp_sample(x_base + offs[k]);
      s.y_sample     = clamp_sample(y_base - offs[k]);
      s.light_sample = clamp_sample(light_base + int'(lim_blink) + (k % 3) - 1);
      pending_samples.push_back(s);
    end
    pending_samples.push_back('{8'h00, 8'hFF, 8'hFF});
    pending_samples.push_back('{8'hFF, 8'h00, 8'h00});
    drain_levels();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_thresholds(8'd5, 8'd10, 8'd15, 8'd50);
        1: apply_thresholds(8'd0, 8'd0, 8'd0, 8'd0);
        2: apply_thresholds(8'd255, 8'd255, 8'd255, 8'd255);
        3: apply_thresholds(8'd40, 8'd20, 8'd5, 8'd0);   // thresholds out of order
        6: apply_thresholds(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: begin
          sm = $urandom_range(40);
          md = sm + int'($urandom_range(40));
          lg = md + int'($urandom_range(60));
          apply_thresholds(sm[7:0], md[7:0], lg[7:0], 8'($urandom));
        end
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int i = 0; i < 225; i++) begin
        if ($urandom_range(99) < 20) begin
          s = in_beat_t'(24'($urandom));
        end else begin
          s.x_sample = clamp_sample(x_base + near_offset());
          s.y_sample = clamp_sample(y_base + near_offset());
          s.light_sample = clamp_sample(light_base + int'(lim_blink) +
                                        int'($urandom_range(4)) - 2);
        end
        pending_samples.push_back(s);
        // let the pipeline empty completely once mid-stream
        if (p == 1 && i == 112) drain_levels();
      end
      drain_levels();
    end

    if (expected_levels.size() != 0)
      report_mismatch($sformatf("%0d level beats never arrived", expected_levels.size()));
    if (mismatch_count == 0) begin
      $display("baseline_calibrated_motion_quantizer_core_test passed");
    end else begin
      $display("baseline_calibrated_motion_quantizer_core_test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("baseline_calibrated_motion_quantizer_core_test failed");
    $finish;
  end

endmodule
